/* design/first_fit_block_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first fit block allocator
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// First fit block allocator package
// Request operation codes, result status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int BLK_W    = 10;
  localparam int BYTE_W   = 23;
  localparam int EXT_W    = 11;
  localparam int STATUS_W = 2;
  localparam int NBLK_W   = BYTE_W + 1;
  localparam int SUM_W    = NBLK_W + 1;

  localparam logic [EXT_W-1:0] EXT_RESET = 11'd1024;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_ALLOC = 2'd2
  } op_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

endpackage

`default_nettype wire

/* design/ffba_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// First fit block allocator
// Used-block map over a flash extent: clear, mark a record, find a free run.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o      | operation, record_valid,
//          |           |                              | run_start, byte_length
//  out     | output    | out_valid_o / out_stall_i    | status, start_block
//  cfg     | input     | cfg_valid_i / cfg_ready_o    | extent_blocks
//
//  The map sits in a one-bit RAM walked one block per cycle by addr_q (clear, mark) or rd_addr_q (scan).
//  Clear sweeps every map entry; mark sets each block of the clipped run.
//  Allocate scans the extent from block 0; the scan stops at the first fitting run.
//  After reset the map is swept to zero first; no request is
//  taken meanwhile. A finished result waits in the output register while the
//  next request is taken; a stalled output holds only the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS      = 1024,
  parameter int BLOCK_SIZE_LOG2 = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ffba_pkg::OP_W-1:0]       operation_i,
  input  wire logic                            record_valid_i,
  input  wire logic [ffba_pkg::BLK_W-1:0]      run_start_i,
  input  wire logic [ffba_pkg::BYTE_W-1:0]     byte_length_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [ffba_pkg::STATUS_W-1:0]   status_o,
  output logic      [ffba_pkg::BLK_W-1:0]      start_block_o,
  // configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ffba_pkg::EXT_W-1:0]      cfg_extent_blocks_i
);

  import ffba_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam int EW = (CW > EXT_W) ? CW : EXT_W;

  localparam logic [NBLK_W-1:0] BS_M1   = NBLK_W'((64'd1 << BLOCK_SIZE_LOG2) - 64'd1);
  localparam logic [CW-1:0]     LAST_BLK = CW'(MAX_BLOCKS - 1);
  localparam logic [EW-1:0]     MAX_EXT  = EW'(MAX_BLOCKS);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic                boot_q, boot_d;
  logic [EXT_W-1:0]    extent_q;
  logic [CW-1:0]       ext_eff;
  logic [EW-1:0]       ext_wide;

  logic [CW-1:0]       addr_q, addr_d;
  logic [CW-1:0]       limit_q, limit_d;
  logic [NBLK_W-1:0]   nblk_q, nblk_d;
  logic [NBLK_W-1:0]   nblk_in;
  logic [BLK_W-1:0]    first_q, first_d;

  logic [CW-1:0]       rd_addr_q, rd_addr_d;
  logic                rd_pend_q, rd_pend_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                issue;
  logic                scan_hit;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [BLK_W-1:0]    res_start_q, res_start_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [BLK_W-1:0]    out_start_q, out_start_d;

  logic [SUM_W-1:0]    mark_end;
  logic [SUM_W-1:0]    first_w;
  logic [SUM_W-1:0]    ext_s;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_wdata;
  logic                ram_rdata;
  logic                in_fire;

  // Used-block map
  ffba_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Clamp the extent to the map size
  assign ext_wide = EW'(extent_q);
  assign ext_eff  = (ext_wide > MAX_EXT) ? CW'(MAX_EXT) : CW'(ext_wide);

  // Round the byte length up to whole blocks
  assign nblk_in = (NBLK_W'(byte_length_i) + BS_M1) >> BLOCK_SIZE_LOG2;

  // Mark range bounds
  assign first_w  = SUM_W'(first_q);
  assign ext_s    = SUM_W'(ext_eff);
  assign mark_end = first_w + SUM_W'(nblk_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    boot_d       = boot_q;
    addr_d       = addr_q;
    limit_d      = limit_q;
    nblk_d       = nblk_q;
    first_d      = first_q;
    rd_addr_d    = rd_addr_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q[AW-1:0];
    ram_wdata    = 1'b0;
    issue        = 1'b0;
    scan_hit     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_start_d  = '0;
          nblk_d       = nblk_in;
          first_d      = run_start_i;
          addr_d       = '0;
          rd_addr_d    = '0;
          cnt_d        = '0;
          case (operation_i)
            OP_CLEAR: state_d = S_CLEAR;
            OP_MARK:  state_d = record_valid_i ? S_PREP : S_DONE;
            OP_ALLOC: begin
              if (nblk_in == '0) begin
                res_status_d = ST_ZERO;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            default:  state_d = S_DONE;
          endcase
        end
      end

      // Sweep every map entry to free
      S_CLEAR: begin
        ram_we = 1'b1;
        if (addr_q == LAST_BLK) begin
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end else begin
          addr_d = addr_q + CW'(1);
        end
      end

      // Clip the record's run at the extent end
      S_PREP: begin
        if (first_w >= ext_s) begin
          addr_d  = '0;
          limit_d = '0;
        end else begin
          addr_d  = CW'(first_q);
          limit_d = (mark_end < ext_s) ? CW'(mark_end) : ext_eff;
        end
        state_d = S_MARK;
      end

      // Set one block used per cycle
      S_MARK: begin
        if (addr_q < limit_q) begin
          ram_we    = 1'b1;
          ram_wdata = 1'b1;
          addr_d    = addr_q + CW'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      // Read ahead one block, count the free run on returning data
      S_SCAN: begin
        issue = (rd_addr_q < ext_eff);
        if (issue) begin
          rd_addr_d = rd_addr_q + CW'(1);
        end
        rd_pend_d = issue;
        rd_idx_d  = rd_addr_q[AW-1:0];
        if (rd_pend_q) begin
          if (ram_rdata) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + CW'(1);
            if (NBLK_W'(cnt_q) + NBLK_W'(1) == nblk_q) begin
              scan_hit = 1'b1;
            end
          end
        end
        if (scan_hit) begin
          res_status_d = ST_OK;
          res_start_d  = BLK_W'(rd_idx_q - cnt_q[AW-1:0]);
          state_d      = S_DONE;
        end else if (!rd_pend_q && !issue) begin
          res_status_d = ST_NOFIT;
          res_start_d  = '0;
          state_d      = S_DONE;
        end
      end

      // Hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = res_start_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      boot_q      <= 1'b1;
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      extent_q    <= EXT_RESET;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      addr_q      <= addr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        extent_q <= cfg_extent_blocks_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    limit_q      <= limit_d;
    nblk_q       <= nblk_d;
    first_q      <= first_d;
    rd_addr_q    <= rd_addr_d;
    rd_idx_q     <= rd_idx_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign start_block_o = out_start_q;

  // Checks
  `FFBA_ASSERT_IMP(a_map_write_state, ram_we, (state_q == S_CLEAR || state_q == S_MARK), "map written outside clear or mark")
  `FFBA_ASSERT_IMP(a_mark_in_extent, (ram_we && state_q == S_MARK), (addr_q < ext_eff), "mark beyond extent end")
  `FFBA_ASSERT_IMP(a_run_below_request, (state_q == S_SCAN), (NBLK_W'(cnt_q) < nblk_q), "free run count passed request")
  `FFBA_ASSERT_NEXT(a_result_from_done, (state_q != S_DONE), !$rose(out_valid_q), "result loaded outside done state")
  `FFBA_ASSERT_IMP(a_boot_blocks_input, boot_q, (state_q == S_CLEAR), "request window open before map sweep ends")

endmodule

`default_nettype wire

/* tb/tb_first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First fit block allocator testbench
// Drives clear, mark and allocate requests through a short directed table and
// a phased random run over several extent sizes. A shadow used-block map or
// the directed table gives every answer, each checked field by field in order.
// ----------------------------------------------------------------------------

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int MAX_BLOCKS      = 1024;
  localparam int BLOCK_SIZE_LOG2 = 12;
  localparam int BLOCK_BYTES     = 1 << BLOCK_SIZE_LOG2;
  localparam int RAND_ITEMS      = 540;
  localparam int NUM_PHASES      = 12;
  localparam int LIMIT_CYCLES    = 4_000_000;
  localparam int TAIL_CYCLES     = 64;
  localparam int CFG_SETTLE      = 4;

  // Operation code 3 is not part of the package enum
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    start_block;
  } answer_t;

  typedef struct {
    bit                 is_cfg;
    logic [EXT_W-1:0]   extent;
    logic [OP_W-1:0]    op;
    logic               rec_ok;
    logic [BLK_W-1:0]   first;
    logic [BYTE_W-1:0]  bytes;
    bit                 typed;
    answer_t            want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i;
  logic                record_valid_i;
  logic [BLK_W-1:0]    run_start_i;
  logic [BYTE_W-1:0]   byte_length_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [BLK_W-1:0]    start_block_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [EXT_W-1:0]    cfg_extent_blocks_i;

  // Shadow of the block map and its extent register
  logic [MAX_BLOCKS-1:0] shadow_used;
  int unsigned           extent_cfg;
  answer_t               awaited_answers[$];
  int                    n_fail;
  bit                    idle_on;
  longint                cyc = 0;

  first_fit_block_allocator #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .BLOCK_SIZE_LOG2 (BLOCK_SIZE_LOG2)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .record_valid_i      (record_valid_i),
    .run_start_i         (run_start_i),
    .byte_length_i       (byte_length_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .start_block_o       (start_block_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_extent_blocks_i (cfg_extent_blocks_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow map and return the answer it gives
  function automatic answer_t shadow_serve(input logic [OP_W-1:0] op, input logic rec_ok,
                                           input logic [BLK_W-1:0] first,
                                           input logic [BYTE_W-1:0] bytes);
    answer_t     res;
    int unsigned lim;
    int unsigned nblk;
    int unsigned run;
    bit          found;
    res.status      = ST_OK;
    res.start_block = '0;
    lim   = (extent_cfg > MAX_BLOCKS) ? MAX_BLOCKS : extent_cfg;
    nblk  = (32'(bytes) + BLOCK_BYTES - 1) >> BLOCK_SIZE_LOG2;
    run   = 0;
    found = 1'b0;
    case (op)
      OP_CLEAR: shadow_used = '0;
      OP_MARK: begin
        // Set the covering blocks, clipped at the extent end
        if (rec_ok) begin
          for (int unsigned b = first; b < lim && b < first + nblk; b++) shadow_used[b] = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (nblk == 0) begin
          res.status = ST_ZERO;
        end else begin
          // Lowest run of nblk free blocks inside the extent
          for (int unsigned b = 0; b < lim && !found; b++) begin
            if (shadow_used[b]) begin
              run = 0;
            end else begin
              run++;
              if (run == nblk) begin
                found           = 1'b1;
                res.start_block = BLK_W'(b + 1 - nblk);
              end
            end
          end
          if (!found) res.status = ST_NOFIT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk_req(input logic [OP_W-1:0] op, input logic rec_ok,
                                       input logic [BLK_W-1:0] first,
                                       input logic [BYTE_W-1:0] bytes);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.extent = '0;
    row.op     = op;
    row.rec_ok = rec_ok;
    row.first  = first;
    row.bytes  = bytes;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_chk(input logic [OP_W-1:0] op, input logic rec_ok,
                                       input logic [BLK_W-1:0] first,
                                       input logic [BYTE_W-1:0] bytes,
                                       input logic [STATUS_W-1:0] st,
                                       input logic [BLK_W-1:0] sb);
    stim_row_t row;
    row                  = mk_req(op, rec_ok, first, bytes);
    row.typed            = 1'b1;
    row.want.status      = st;
    row.want.start_block = sb;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [EXT_W-1:0] blocks);
    stim_row_t row;
    row        = mk_req(OP_CLEAR, 1'b0, '0, '0);
    row.is_cfg = 1'b1;
    row.extent = blocks;
    return row;
  endfunction

  // Byte length of mostly a few blocks, now and then up to one block past the extent
  function automatic logic [BYTE_W-1:0] pick_length(input int unsigned lim);
    int unsigned k;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lim + 1)
                                    : $urandom_range(0, lim / 4 + 2);
    if (k == 0) return '0;
    return BYTE_W'(((k - 1) << BLOCK_SIZE_LOG2) + $urandom_range(1, BLOCK_BYTES));
  endfunction

  // Offer one request, hold it until taken, then record its answer
  task automatic send_request(input logic [OP_W-1:0] op, input logic rec_ok,
                              input logic [BLK_W-1:0] first, input logic [BYTE_W-1:0] bytes,
                              input bit typed, input answer_t want, output answer_t got);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    record_valid_i <= rec_ok;
    run_start_i    <= first;
    byte_length_i  <= bytes;
    do @(posedge clk_i); while (in_stall_o);
    got = shadow_serve(op, rec_ok, first, bytes);
    awaited_answers.push_back(typed ? want : got);
  endtask

  // Hold off new requests until every answer is back
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_extent(input logic [EXT_W-1:0] blocks);
    drain_answers();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_extent_blocks_i <= blocks;
    do @(posedge clk_i); while (!cfg_ready_o);
    extent_cfg  = blocks;
    cfg_valid_i <= 1'b0;
  endtask

  // Random backpressure on the answer side
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 8);
  end

  // Check each answer against the oldest one awaited
  always @(posedge clk_i) begin : watch_answers
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_answers.size() == 0) begin
        $error("answer with none awaited: status %0d start_block %0d", status_o,
               start_block_o);
        n_fail++;
      end else begin
        want = awaited_answers.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          n_fail++;
        end
        if (start_block_o !== want.start_block) begin
          $error("start_block: expected %0d, actual %0d", want.start_block, start_block_o);
          n_fail++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t        dir_table[$];
    answer_t          got;
    int unsigned      lim;
    int               sent;
    int               pick;
    logic [EXT_W-1:0] ext;
    logic [BYTE_W-1:0] len;

    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    operation_i         = '0;
    record_valid_i      = 1'b0;
    run_start_i         = '0;
    byte_length_i       = '0;
    cfg_valid_i         = 1'b0;
    cfg_extent_blocks_i = '0;
    idle_on             = 1'b1;
    shadow_used         = '0;
    extent_cfg          = EXT_RESET;
    n_fail              = 0;
    sent                = 0;

    // Directed table: reset extent first, then empty, oversized and single block
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd1, ST_OK, 10'd0));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd0, ST_ZERO, 10'd0));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd4194304, ST_OK, 10'd0));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'h7FFFFF, ST_NOFIT, 10'd0));
    dir_table.push_back(mk_chk(OP_RESERVED, 1'b1, 10'h3FF, 23'h7FFFFF, ST_OK, 10'd0));
    dir_table.push_back(mk_chk(OP_MARK, 1'b0, 10'd0, 23'd4096, ST_OK, 10'd0));
    dir_table.push_back(mk_chk(OP_MARK, 1'b1, 10'd0, 23'd0, ST_OK, 10'd0));
    dir_table.push_back(mk_chk(OP_MARK, 1'b1, 10'd0, 23'd4097, ST_OK, 10'd0));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd4096));
    dir_table.push_back(mk_chk(OP_MARK, 1'b1, 10'h3FF, 23'h7FFFFF, ST_OK, 10'd0));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b1, 10'h2AA, 23'd4194304));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd4182016));
    dir_table.push_back(mk_req(OP_MARK, 1'b1, 10'd5, 23'd1));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd12288));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd16384));
    dir_table.push_back(mk_chk(OP_CLEAR, 1'b1, 10'h155, 23'h555555, ST_OK, 10'd0));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd4194304));
    // Empty extent
    dir_table.push_back(mk_cfg(11'd0));
    dir_table.push_back(mk_req(OP_MARK, 1'b1, 10'd0, 23'd4096));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd1, ST_NOFIT, 10'd0));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd0, ST_ZERO, 10'd0));
    // Extent above the map size
    dir_table.push_back(mk_cfg(11'h7FF));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd4194304));
    dir_table.push_back(mk_req(OP_MARK, 1'b1, 10'h3FF, 23'd8192));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd4194304));
    // One-block extent: mark past the end, request larger than the extent
    dir_table.push_back(mk_cfg(11'd1));
    dir_table.push_back(mk_req(OP_MARK, 1'b1, 10'd1, 23'd4096));
    dir_table.push_back(mk_req(OP_ALLOC, 1'b0, 10'd0, 23'd1));
    dir_table.push_back(mk_chk(OP_ALLOC, 1'b0, 10'd0, 23'd8192, ST_NOFIT, 10'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        write_extent(dir_table[i].extent);
      end else begin
        send_request(dir_table[i].op, dir_table[i].rec_ok, dir_table[i].first,
                     dir_table[i].bytes, dir_table[i].typed, dir_table[i].want, got);
      end
    end

    // Random phases, each at its own extent; phase 2 runs with no idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       ext = 11'd1;
        3:       ext = EXT_RESET;
        4:       ext = 11'd0;
        6:       ext = 11'h7FF;
        9:       ext = EXT_W'($urandom_range(65, 2047));
        default: ext = EXT_W'($urandom_range(2, 64));
      endcase
      write_extent(ext);
      idle_on = (p != 2);
      lim     = (extent_cfg > MAX_BLOCKS) ? MAX_BLOCKS : extent_cfg;
      while (sent < (p + 1) * RAND_ITEMS / NUM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick == 0) drain_answers();
        if (pick < 5) begin
          send_request(OP_CLEAR, 1'($urandom), BLK_W'($urandom), BYTE_W'($urandom),
                       1'b0, '0, got);
          sent++;
        end else if (pick < 8) begin
          send_request(OP_RESERVED, 1'($urandom), BLK_W'($urandom), BYTE_W'($urandom),
                       1'b0, '0, got);
        end else if (pick < 12) begin
          send_request(OP_MARK, 1'b0, BLK_W'($urandom), BYTE_W'($urandom), 1'b0, '0, got);
        end else if (pick < 42) begin
          send_request(OP_MARK, 1'b1, BLK_W'($urandom_range(0, lim + 2)), pick_length(lim),
                       1'b0, '0, got);
          sent++;
        end else if (pick < 48) begin
          send_request(OP_MARK, 1'b1, BLK_W'($urandom), BYTE_W'($urandom), 1'b0, '0, got);
          sent++;
        end else if (pick < 92) begin
          // Allocate, then often commit the granted run as a record
          len = pick_length(lim);
          send_request(OP_ALLOC, 1'($urandom), BLK_W'($urandom), len, 1'b0, '0, got);
          sent++;
          if (got.status == ST_OK && $urandom_range(0, 1) == 1) begin
            send_request(OP_MARK, 1'b1, got.start_block, len, 1'b0, '0, got);
            sent++;
          end
        end else begin
          send_request(OP_ALLOC, 1'($urandom), BLK_W'($urandom), BYTE_W'($urandom),
                       1'b0, '0, got);
          sent++;
        end
      end
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
